// ----- sv/coalesced_hash_table_top_macros.svh -----
// Assertion macros shared by the coalesced hash table RTL
`ifndef COALESCED_HASH_TABLE_TOP_MACROS_SVH
`define COALESCED_HASH_TABLE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define CHT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define CHT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cht_pkg.sv -----
// Shared types and constants for the coalesced hash table
package cht_pkg;

    localparam int TABLE_SIZE_DEF = 64;
    localparam int KEY_W          = 32;
    localparam int SLOT_W         = 6;
    localparam int STATUS_W       = 3;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_FIND   = 1'b1
    } cht_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_FOUND     = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } cht_status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_RD,
        S_CHK,
        S_PRB_RD,
        S_PRB_CHK,
        S_DONE
    } cht_state_t;

    // Write strobes and flag data for the slot store
    typedef struct packed {
        logic slot_we;
        logic used_wd;
        logic link_we;
        logic lv_wd;
    } cht_wr_t;

endpackage

// ----- sv/cht_mod_unit.sv -----
// Key modulo table size by reciprocal multiplication and one correcting subtract
module cht_mod_unit
    import cht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [KEY_W-1:0]              dividend,
    output logic                          done,
    output logic [$clog2(TABLE_SIZE)-1:0] remainder
);

    localparam int IDXW = $clog2(TABLE_SIZE);
    localparam int RW   = IDXW + 1;
    localparam int PW   = 2 * KEY_W;
    // Reciprocal rounded down: the quotient estimate is exact or one short
    localparam logic [KEY_W-1:0] RECIP = KEY_W'((PW'(1) << KEY_W) / PW'(TABLE_SIZE));
    localparam logic [KEY_W-1:0] TS_K  = KEY_W'(TABLE_SIZE);
    localparam logic [RW-1:0]    TS_R  = RW'(TABLE_SIZE);

    logic [3:0]       stage_reg, stage_next;
    logic [KEY_W-1:0] num_reg,   num_next;
    logic [PW-1:0]    prod_reg,  prod_next;
    logic [KEY_W-1:0] qd_reg,    qd_next;
    logic [RW-1:0]    rem_reg,   rem_next;
    logic [KEY_W-1:0] diff;
    logic [RW-1:0]    rem_raw;

    // Quotient estimate times table size never exceeds the key, and the difference
    // stays below twice the table size
    assign diff    = num_reg - qd_reg;
    assign rem_raw = diff[RW-1:0];

    always_comb
    begin
        stage_next = {stage_reg[2:0], start};
        num_next   = start ? dividend : num_reg;
        prod_next  = PW'(num_reg) * PW'(RECIP);
        qd_next    = prod_reg[PW-1:KEY_W] * TS_K;
        // Correct an estimate that came out one short
        rem_next   = (rem_raw >= TS_R) ? (rem_raw - TS_R) : rem_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        prod_reg <= prod_next;
        qd_reg   <= qd_next;
        rem_reg  <= rem_next;
    end

    assign done      = stage_reg[3];
    assign remainder = rem_reg[IDXW-1:0];

endmodule

// ----- sv/cht_mem.sv -----
// Slot store: key, used flag, link and link-valid flag per slot
module cht_mem
    import cht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
    input  logic                          clk,
    input  logic [$clog2(TABLE_SIZE)-1:0] raddr,
    input  cht_wr_t                       wr,
    input  logic [$clog2(TABLE_SIZE)-1:0] slot_waddr,
    input  logic [KEY_W-1:0]              key_wdata,
    input  logic [$clog2(TABLE_SIZE)-1:0] link_waddr,
    input  logic [$clog2(TABLE_SIZE)-1:0] link_wdata,
    output logic [KEY_W-1:0]              rd_key,
    output logic                          rd_used,
    output logic [$clog2(TABLE_SIZE)-1:0] rd_link,
    output logic                          rd_lv
);

    localparam int IDXW = $clog2(TABLE_SIZE);

    logic [KEY_W-1:0] key_mem  [TABLE_SIZE];
    logic             used_mem [TABLE_SIZE];
    logic [IDXW-1:0]  link_mem [TABLE_SIZE];
    logic             lv_mem   [TABLE_SIZE];

    always_ff @(posedge clk)
    begin
        if (wr.slot_we)
        begin
            key_mem[slot_waddr]  <= key_wdata;
            used_mem[slot_waddr] <= wr.used_wd;
        end
        if (wr.link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
            lv_mem[link_waddr]   <= wr.lv_wd;
        end
        rd_key  <= key_mem[raddr];
        rd_used <= used_mem[raddr];
        rd_link <= link_mem[raddr];
        rd_lv   <= lv_mem[raddr];
    end

endmodule

// ----- sv/coalesced_hash_table_top.sv -----
// Coalesced hash table: an item is accepted, its home slot is found (key modulo TABLE_SIZE by
// reciprocal multiplication, a multiply back and one correcting subtract), each slot visited on
// the chain and each linear probe is a read and a check of the slot store (one read port with
// registered data), and the result is handed to the output register. One item is worked on at
// a time and in_stall is high until its result is loaded. After reset a clearing pass over every
// slot resets the used and link flags, and no item is taken during it.
`include "coalesced_hash_table_top_macros.svh"

module coalesced_hash_table_top
    import cht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                opcode,
    input  logic [KEY_W-1:0]    search_key,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot_index
);

    localparam int IDXW = $clog2(TABLE_SIZE);
    localparam int RW   = IDXW + 1;
    localparam logic [RW-1:0]   TS_R = RW'(TABLE_SIZE);
    localparam logic [IDXW-1:0] LAST = IDXW'(TABLE_SIZE - 1);

    cht_state_t       state_reg, state_next;
    cht_op_t          op_reg,    op_next;
    logic [KEY_W-1:0] key_reg,   key_next;
    logic [IDXW-1:0]  cur_reg,   cur_next;
    logic [RW-1:0]    steps_reg, steps_next;
    logic [IDXW-1:0]  tail_reg,  tail_next;
    logic [IDXW-1:0]  prb_reg,   prb_next;
    logic [IDXW-1:0]  pcnt_reg,  pcnt_next;
    cht_status_t      res_status_reg, res_status_next;
    logic [IDXW-1:0]  res_slot_reg,   res_slot_next;
    logic             out_valid_reg,  out_valid_next;
    logic [STATUS_W-1:0] status_reg,  status_next;
    logic [SLOT_W-1:0]   slot_reg,    slot_next;
    logic [IDXW+SLOT_W-1:0] slot_ext;

    logic             out_load;
    logic             mod_start;
    logic             mod_done;
    logic [IDXW-1:0]  mod_rem;
    logic [IDXW-1:0]  cur_inc;
    logic [IDXW-1:0]  prb_inc;
    logic             key_hit;

    logic [IDXW-1:0]  raddr;
    cht_wr_t          wr;
    logic [IDXW-1:0]  slot_waddr;
    logic [KEY_W-1:0] key_wdata;
    logic [IDXW-1:0]  link_waddr;
    logic [IDXW-1:0]  link_wdata;
    logic [KEY_W-1:0] rd_key;
    logic             rd_used;
    logic [IDXW-1:0]  rd_link;
    logic             rd_lv;

    cht_mod_unit #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (search_key),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    cht_mem #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_mem (
        .clk        (clk),
        .raddr      (raddr),
        .wr         (wr),
        .slot_waddr (slot_waddr),
        .key_wdata  (key_wdata),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .rd_key     (rd_key),
        .rd_used    (rd_used),
        .rd_link    (rd_link),
        .rd_lv      (rd_lv)
    );

    assign cur_inc = (cur_reg == LAST) ? '0 : cur_reg + IDXW'(1);
    assign prb_inc = (prb_reg == LAST) ? '0 : prb_reg + IDXW'(1);
    assign key_hit = (rd_key == key_reg);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (cur_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                priority if (!rd_used || key_hit)
                begin
                    state_next = S_DONE;
                end
                else if (rd_lv && (steps_reg < TS_R))
                begin
                    state_next = S_RD;
                end
                else if (op_reg == OP_FIND)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PRB_RD;
                end
            end
            S_PRB_RD:
            begin
                state_next = S_PRB_CHK;
            end
            S_PRB_CHK:
            begin
                if (!rd_used || (pcnt_reg == LAST))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PRB_RD;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and store control
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        tail_next       = tail_reg;
        prb_next        = prb_reg;
        pcnt_next       = pcnt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        mod_start       = 1'b0;
        raddr           = cur_reg;
        wr              = '0;
        slot_waddr      = cur_reg;
        key_wdata       = key_reg;
        link_waddr      = tail_reg;
        link_wdata      = prb_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr.slot_we = 1'b1;
                wr.link_we = 1'b1;
                link_waddr = cur_reg;
                cur_next   = cur_inc;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = cht_op_t'(opcode);
                    key_next   = search_key;
                    steps_next = '0;
                    mod_start  = 1'b1;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    cur_next = mod_rem;
                end
            end
            S_RD:
            begin
                raddr = cur_reg;
            end
            S_CHK:
            begin
                priority if (!rd_used)
                begin
                    // Only the home slot can be empty here
                    if (op_reg == OP_FIND)
                    begin
                        res_status_next = STAT_NOT_FOUND;
                        res_slot_next   = '0;
                    end
                    else
                    begin
                        wr.slot_we      = 1'b1;
                        wr.used_wd      = 1'b1;
                        res_status_next = STAT_INSERTED;
                        res_slot_next   = cur_reg;
                    end
                end
                else if (key_hit)
                begin
                    if (op_reg == OP_FIND)
                    begin
                        res_status_next = STAT_FOUND;
                        res_slot_next   = cur_reg;
                    end
                    else
                    begin
                        res_status_next = STAT_DUPLICATE;
                        res_slot_next   = '0;
                    end
                end
                else if (rd_lv && (steps_reg < TS_R))
                begin
                    cur_next   = rd_link;
                    steps_next = steps_reg + RW'(1);
                end
                else
                begin
                    // End of chain: miss for a find, start probing after the tail for an insert
                    res_status_next = STAT_NOT_FOUND;
                    res_slot_next   = '0;
                    tail_next       = cur_reg;
                    prb_next        = cur_inc;
                    pcnt_next       = IDXW'(1);
                end
            end
            S_PRB_RD:
            begin
                raddr = prb_reg;
            end
            S_PRB_CHK:
            begin
                priority if (!rd_used)
                begin
                    wr.slot_we      = 1'b1;
                    wr.used_wd      = 1'b1;
                    wr.link_we      = 1'b1;
                    wr.lv_wd        = 1'b1;
                    slot_waddr      = prb_reg;
                    link_waddr      = tail_reg;
                    link_wdata      = prb_reg;
                    res_status_next = STAT_INSERTED;
                    res_slot_next   = prb_reg;
                end
                else if (pcnt_reg == LAST)
                begin
                    res_status_next = STAT_FULL;
                    res_slot_next   = '0;
                end
                else
                begin
                    prb_next  = prb_inc;
                    pcnt_next = pcnt_reg + IDXW'(1);
                end
            end
            S_DONE:
            begin
                raddr = cur_reg;
            end
            default:
            begin
                raddr = cur_reg;
            end
        endcase
    end

    // Output register: hold while stalled, load when free or draining
    assign slot_ext       = {{SLOT_W{1'b0}}, res_slot_reg};
    assign out_valid_next = out_load || (out_valid_reg && out_stall);
    assign status_next    = out_load ? res_status_reg : status_reg;
    assign slot_next      = out_load ? slot_ext[SLOT_W-1:0] : slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cur_reg       <= '0;
            steps_reg     <= '0;
            pcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            steps_reg     <= steps_next;
            pcnt_reg      <= pcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        tail_reg       <= tail_next;
        prb_reg        <= prb_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        status_reg     <= status_next;
        slot_reg       <= slot_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_index = slot_reg;

    `CHT_ASSERT_NXT(a_accept_starts_mod, in_valid && !in_stall, state_reg == S_MOD,
        "accepted transfer did not start the modulo step")
    `CHT_ASSERT_IMP(a_zero_slot, out_valid && (status == STAT_DUPLICATE ||
        status == STAT_FULL || status == STAT_NOT_FOUND), slot_index == '0,
        "non-zero slot reported with a failing status")
    `CHT_ASSERT_IMP(a_steps_bound, state_reg == S_CHK, steps_reg <= TS_R,
        "chain walk ran past the table size")
    `CHT_ASSERT_NXT(a_probe_insert, state_reg == S_PRB_CHK && !rd_used,
        state_reg == S_DONE && res_status_reg == STAT_INSERTED,
        "empty probe slot did not finish as an insert")
    `CHT_ASSERT_IMP(a_result_from_done, $rose(out_valid), $past(state_reg) == S_DONE,
        "result appeared outside the done state")

endmodule

// ----- verif/tb_coalesced_hash_table_top.sv -----
// Self-checking testbench for the coalesced hash table: inserts and finds against a shadow table
`timescale 1ns / 1ps

module tb_coalesced_hash_table_top;
    import cht_pkg::*;

    localparam int SLOTS        = TABLE_SIZE_DEF;
    localparam int RANDOM_ITEMS = 930;
    localparam int SETTLE_CYCLES = 4 * SLOTS + 64;
    localparam int QUIET_LIMIT  = 6000;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        cht_status_t          st;
        logic [SLOT_W-1:0]    slot;
    } outcome_t;

    typedef struct {
        cht_op_t              op;
        logic [KEY_W-1:0]     key;
        bit                   sync;
    } request_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 opcode = 1'b0;
    logic [KEY_W-1:0]     search_key = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    slot_index;

    // Shadow copy of the slot store
    bit [KEY_W-1:0]       shadow_key [SLOTS];
    bit                   shadow_used [SLOTS];
    bit                   shadow_linked [SLOTS];
    int                   shadow_next [SLOTS];

    request_t             request_q [$];
    outcome_t             outcome_q [$];
    logic [KEY_W-1:0]     known_keys [$];

    int                   total_items;
    int                   sent_cnt;
    int                   recv_cnt;
    int                   error_count;
    int                   quiet_cycles;
    int                   hold_left;
    bit                   hold_done;
    int                   send_idle;
    int                   recv_stall;
    request_t             next_req;
    outcome_t             want;

    coalesced_hash_table_top #(
        .TABLE_SIZE (SLOTS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .search_key (search_key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .slot_index (slot_index)
    );

    always #6 clk = ~clk;

    // Follow the chain from head; the last slot visited becomes the tail
    function automatic bit chain_search(input int head, input logic [KEY_W-1:0] key,
                                        output int hit, output int tail);
        int cur;
        int nxt;
        int steps;
        cur = head;
        steps = 0;
        hit = 0;
        if (shadow_key[cur] == key)
        begin
            hit = cur;
            tail = cur;
            return 1'b1;
        end
        while (shadow_linked[cur] && steps < SLOTS)
        begin
            nxt = shadow_next[cur];
            if (shadow_key[nxt] == key)
            begin
                hit = nxt;
                tail = nxt;
                return 1'b1;
            end
            cur = nxt;
            steps++;
        end
        tail = cur;
        return 1'b0;
    endfunction

    function automatic outcome_t shadow_table_step(input cht_op_t op,
                                                   input logic [KEY_W-1:0] key);
        outcome_t res;
        int home;
        int hit;
        int tail;
        int p;
        home = int'(key % SLOTS);
        res.st = STAT_NOT_FOUND;
        res.slot = '0;
        if (op == OP_FIND)
        begin
            if (shadow_used[home] && chain_search(home, key, hit, tail))
            begin
                res.st = STAT_FOUND;
                res.slot = SLOT_W'(hit);
            end
        end
        else if (!shadow_used[home])
        begin
            shadow_key[home] = key;
            shadow_used[home] = 1'b1;
            res.st = STAT_INSERTED;
            res.slot = SLOT_W'(home);
        end
        else if (chain_search(home, key, hit, tail))
        begin
            res.st = STAT_DUPLICATE;
        end
        else
        begin
            // Probe linearly from the tail; leave the table alone when nothing is free
            res.st = STAT_FULL;
            for (int i = 1; i < SLOTS; i++)
            begin
                p = (tail + i) % SLOTS;
                if (!shadow_used[p])
                begin
                    shadow_key[p] = key;
                    shadow_used[p] = 1'b1;
                    shadow_next[tail] = p;
                    shadow_linked[tail] = 1'b1;
                    res.st = STAT_INSERTED;
                    res.slot = SLOT_W'(p);
                    break;
                end
            end
        end
        return res;
    endfunction

    task automatic queue_request(input cht_op_t op, input logic [KEY_W-1:0] key,
                                 input bit sync);
        request_t r;
        r.op = op;
        r.key = key;
        r.sync = sync;
        request_q.push_back(r);
        if (op == OP_INSERT)
            known_keys.push_back(key);
    endtask

    task automatic report_mismatch(input string field, input int wanted, input int got);
        error_count++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, wanted, got);
    endtask

    // Driver: offer pending transfers, predict each one as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode <= 1'b0;
            search_key <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                outcome_q.push_back(shadow_table_step(cht_op_t'(opcode), search_key));
                sent_cnt++;
            end
            if (!in_valid || !in_stall)
            begin
                send_idle = (sent_cnt < total_items / 3) ? 6 :
                            (sent_cnt < 2 * total_items / 3) ? 57 : 0;
                // A sync item waits until every earlier result has come back
                if (request_q.size() != 0 && (!request_q[0].sync || recv_cnt == sent_cnt)
                    && $urandom_range(99) >= send_idle)
                begin
                    next_req = request_q.pop_front();
                    in_valid <= 1'b1;
                    opcode <= next_req.op;
                    search_key <= next_req.key;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer and drive the receiver's stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_cnt <= 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (outcome_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t ns: unexpected result, expected none, actual status %0d slot %0d",
                             $time, status, slot_index);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", want.st, status);
                    if (slot_index !== want.slot)
                        report_mismatch("slot_index", want.slot, slot_index);
                end
                recv_cnt <= recv_cnt + 1;
            end
            recv_stall = (recv_cnt < total_items / 3) ? 57 :
                         (recv_cnt < 2 * total_items / 3) ? 6 : 0;
            if (!hold_done && recv_cnt == HOLD_AT)
            begin
                // Hold off long enough for the block to back up onto its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall);
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int roll;
        logic [KEY_W-1:0] fresh;
        logic [KEY_W-1:0] pick;
        bit sync;

        // Empty home, insert, duplicate, found, and both ends of the key range
        queue_request(OP_FIND,   32'h0000_0000, 1'b0);
        queue_request(OP_INSERT, 32'h0000_0000, 1'b0);
        queue_request(OP_INSERT, 32'h0000_0000, 1'b0);
        queue_request(OP_FIND,   32'h0000_0000, 1'b0);
        queue_request(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
        // Collision at the top slot: probing wraps round past slot zero
        queue_request(OP_INSERT, 32'h7FFF_FFFF, 1'b0);
        queue_request(OP_INSERT, 32'h0000_0040, 1'b0);
        queue_request(OP_FIND,   32'h7FFF_FFFF, 1'b0);
        queue_request(OP_FIND,   32'h0000_0040, 1'b0);
        queue_request(OP_FIND,   32'h0000_0080, 1'b0);
        queue_request(OP_INSERT, 32'hFFFF_FFBF, 1'b0);
        // Home slot taken by another chain: chains coalesce
        queue_request(OP_INSERT, 32'h8000_0001, 1'b0);
        queue_request(OP_FIND,   32'h8000_0001, 1'b0);
        queue_request(OP_FIND,   32'hFFFF_FFBF, 1'b0);
        queue_request(OP_INSERT, 32'h7FFF_FFFF, 1'b0);
        queue_request(OP_FIND,   32'hFFFF_FFFF, 1'b0);
        queue_request(OP_FIND,   32'h1234_5678, 1'b0);
        queue_request(OP_INSERT, 32'hAAAA_AAAA, 1'b0);
        queue_request(OP_INSERT, 32'h5555_5555, 1'b0);
        queue_request(OP_FIND,   32'h5555_5555, 1'b0);
        queue_request(OP_FIND,   32'hAAAA_AAAA, 1'b0);

        // Fresh inserts are kept rare so the table fills part way through the run
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(99);
            sync = (n == 280 || n == 620);
            fresh = $urandom();
            if ($urandom_range(1) == 1)
                fresh[SLOT_W-1:0] = known_keys[$urandom_range(known_keys.size() - 1)][SLOT_W-1:0];
            pick = known_keys[$urandom_range(known_keys.size() - 1)];
            if (roll < 12)
                queue_request(OP_INSERT, fresh, sync);
            else if (roll < 27)
                queue_request(OP_INSERT, pick, sync);
            else if (roll < 75)
                queue_request(OP_FIND, pick, sync);
            else
                queue_request(OP_FIND, fresh, sync);
        end
        total_items = request_q.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || in_valid || outcome_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (outcome_q.size() != 0)
            error_count++;

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
